[rtl/core/ipcc_pkg.sv]
// ----------------------------------------------------------------------------
// ipcc_pkg
// Shared widths, register codes, payload types and control structs for the
// inserted point clash check.
// ----------------------------------------------------------------------------
package ipcc_pkg;

  localparam int COORD_W    = 24;
  localparam int FI_W       = 8;
  localparam int BOX_W      = 24;
  localparam int DIST_W     = 25;
  localparam int PIDX_W     = 9;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  localparam int MAX_POINTS_DEF = 256;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_INSERTED = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LENGTH     = 8'd1;

  localparam logic [FI_W-1:0]  FI_RESET  = 8'd96;
  localparam logic [BOX_W-1:0] BOX_RESET = 24'd792986;  // 12.10 in Q8.16

  typedef struct packed {
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic               final_point;
  } point_t;

  typedef struct packed {
    logic [DIST_W-1:0] min_distance;
    logic [PIDX_W-1:0] problem_index;
    logic              too_few;
  } result_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } coords_t;

  typedef struct packed {
    logic wr_en;       // store incoming point
    logic rd_en;       // read point store
    logic load_pi;     // read data becomes the pivot point
    logic pair_valid;  // read data pairs with the pivot
    logic pair_ref;    // this pair is the reference pair
    logic init;        // start of a new check
    logic too_few;     // fewer than two points in the set
    logic load_out;    // capture result word
  } cmd_t;

  typedef struct packed {
    logic ref_done;    // reference distance available next cycle
    logic busy;        // pairs still in flight
  } status_t;

endpackage

[rtl/core/inserted_point_clash_check_top.sv]
// Points without the final mark load at one per cycle while the block is idle.
// A final point starts the check: the reference pair (points 1 and 0) first, then
// each pivot i from first_inserted up is loaded and paired with its i earlier points,
// then the difference/square/sum path and the 25-stage root drain, and the result
// word is registered. No point is taken while a check runs.
// Reset clears the point count and loads register defaults; the store is not cleared.
// ----------------------------------------------------------------------------
// inserted_point_clash_check_top
// Loads 3-D points, then reports the minimum distance over the reference pair and the
// pairs of each inserted point, and the last inserted index that clashes with an earlier point.
// ----------------------------------------------------------------------------
module inserted_point_clash_check_top
  import ipcc_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  point_valid,
  output logic                  point_stall,
  input  point_t                point,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  logic [FI_W-1:0]  first_inserted;
  logic [BOX_W-1:0] box_length;

  cmd_t             cmd;
  status_t          status;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic [CNT_W-1:0] pair_idx, init_n;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_inserted <= FI_RESET;
      box_length     <= BOX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FIRST_INSERTED) begin
        first_inserted <= cfg_data[FI_W-1:0];
      end else if (cfg_index == REG_BOX_LENGTH) begin
        box_length <= cfg_data[BOX_W-1:0];
      end
    end
  end

  ipcc_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .point_valid    (point_valid),
    .final_point    (point.final_point),
    .point_stall    (point_stall),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .first_inserted (first_inserted),
    .cmd            (cmd),
    .status         (status),
    .wr_addr        (wr_addr),
    .rd_addr        (rd_addr),
    .pair_idx       (pair_idx),
    .init_n         (init_n)
  );

  ipcc_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .pair_idx   (pair_idx),
    .init_n     (init_n),
    .wr_point   (point),
    .box_length (box_length),
    .result     (result)
  );

endmodule

[rtl/core/ipcc_sqrt.sv]
// ----------------------------------------------------------------------------
// ipcc_sqrt
// Pipelined integer square root, one result bit per stage, floor rounding.
// ----------------------------------------------------------------------------
module ipcc_sqrt
  import ipcc_pkg::*;
#(
  parameter int TAG_W = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  in_value,
  input  logic [TAG_W-1:0]  in_tag,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output logic [TAG_W-1:0]  out_tag,
  output logic              busy
);

  logic [ROOT_W-1:0] st_valid;
  logic [ROOT_W-1:0] st_root [ROOT_W];
  logic [REM_W-1:0]  st_rem  [ROOT_W];
  logic [SUM_W-1:0]  st_val  [ROOT_W];
  logic [TAG_W-1:0]  st_tag  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              p_valid;
    logic [ROOT_W-1:0] p_root;
    logic [REM_W-1:0]  p_rem;
    logic [SUM_W-1:0]  p_val;
    logic [TAG_W-1:0]  p_tag;
    logic [REM_W+1:0]  cat;
    logic [REM_W+1:0]  trial;
    logic [REM_W+2:0]  diff;

    if (k == 0) begin : g_first
      assign p_valid = in_valid;
      assign p_root  = '0;
      assign p_rem   = '0;
      assign p_val   = in_value;
      assign p_tag   = in_tag;
    end else begin : g_next
      assign p_valid = st_valid[k-1];
      assign p_root  = st_root[k-1];
      assign p_rem   = st_rem[k-1];
      assign p_val   = st_val[k-1];
      assign p_tag   = st_tag[k-1];
    end

    always_comb begin
      cat   = {p_rem, p_val[SUM_W-1 -: 2]};
      trial = (REM_W + 2)'({p_root, 2'b01});
      diff  = {1'b0, cat} - {1'b0, trial};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else begin
        st_valid[k] <= p_valid;
      end
      st_tag[k] <= p_tag;
      st_val[k] <= {p_val[SUM_W-3:0], 2'b00};
      if (!diff[REM_W+2]) begin
        st_rem[k]  <= diff[REM_W-1:0];
        st_root[k] <= {p_root[ROOT_W-2:0], 1'b1};
      end else begin
        st_rem[k]  <= cat[REM_W-1:0];
        st_root[k] <= {p_root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = st_valid[ROOT_W-1];
  assign out_root  = st_root[ROOT_W-1];
  assign out_tag   = st_tag[ROOT_W-1];
  assign busy      = |st_valid;

endmodule

[rtl/core/ipcc_dpath.sv]
// ----------------------------------------------------------------------------
// ipcc_dpath
// Point store, distance pipeline and running minimum / offender tracking.
// ----------------------------------------------------------------------------
module ipcc_dpath
  import ipcc_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cmd_t                                   cmd,
  output status_t                                status,
  input  logic [$clog2(MAX_POINTS)-1:0]          wr_addr,
  input  logic [$clog2(MAX_POINTS)-1:0]          rd_addr,
  input  logic [$clog2(MAX_POINTS + 1)-1:0]      pair_idx,
  input  logic [$clog2(MAX_POINTS + 1)-1:0]      init_n,
  input  point_t                                 wr_point,
  input  logic [BOX_W-1:0]                       box_length,
  output result_t                                result
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int TAG_W = CNT_W + 1;   // {ref flag, index}
  localparam int CMP_W = DIST_W + 2;

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  coords_t mem [MAX_POINTS];
  coords_t memq;
  coords_t pivot;

  logic             v1, v2, v3, v4, ld1;
  logic [TAG_W-1:0] tag1, tag2, tag3, tag4;
  logic [COORD_W-1:0] dx, dy, dz;
  logic [SQ_W-1:0]    sqx, sqy, sqz;
  logic [SUM_W-1:0]   sum;

  logic              sq_valid, sq_busy;
  logic [ROOT_W-1:0] sq_root;
  logic [TAG_W-1:0]  sq_tag;

  logic [DIST_W-1:0]       ref_d, best;
  logic signed [CMP_W-1:0] lo, hi, sd;
  logic [CNT_W-1:0]        prob;
  logic                    too_few;
  logic [CNT_W+PIDX_W-1:0] prob_ext;

  // store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= '{x: wr_point.coord_x, y: wr_point.coord_y, z: wr_point.coord_z};
    end
    if (cmd.rd_en) begin
      memq <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      ld1 <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
    end else begin
      v1  <= cmd.pair_valid;
      ld1 <= cmd.load_pi;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
    end
    tag1 <= {cmd.pair_ref, pair_idx};
    tag2 <= tag1;
    tag3 <= tag2;
    tag4 <= tag3;
    if (ld1) begin
      pivot <= memq;
    end
    dx  <= abs_diff(pivot.x, memq.x);
    dy  <= abs_diff(pivot.y, memq.y);
    dz  <= abs_diff(pivot.z, memq.z);
    sqx <= dx * dx;
    sqy <= dy * dy;
    sqz <= dz * dz;
    sum <= SUM_W'(sqx) + SUM_W'(sqy) + SUM_W'(sqz);
  end

  ipcc_sqrt #(
    .TAG_W (TAG_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_value  (sum),
    .in_tag    (tag4),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_tag   (sq_tag),
    .busy      (sq_busy)
  );

  assign sd = $signed(CMP_W'(sq_root));

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      prob    <= init_n;
      too_few <= cmd.too_few;
    end
    if (sq_valid) begin
      if (sq_tag[TAG_W-1]) begin
        ref_d <= sq_root;
        best  <= sq_root;
        // window around the box length; lower edge may go negative
        lo    <= $signed(CMP_W'(box_length)) - $signed(CMP_W'(sq_root));
        hi    <= $signed(CMP_W'(box_length)) + $signed(CMP_W'(sq_root));
      end else begin
        if (sq_root < best) begin
          best <= sq_root;
        end
        if (sq_root < ref_d || (sd <= hi && sd >= lo)) begin
          prob <= sq_tag[CNT_W-1:0];
        end
      end
    end
  end

  assign prob_ext = (CNT_W + PIDX_W)'(prob);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.min_distance  <= too_few ? '0 : best;
      result.problem_index <= prob_ext[PIDX_W-1:0];
      result.too_few       <= too_few;
    end
  end

  assign status.ref_done = sq_valid & sq_tag[TAG_W-1];
  assign status.busy     = v1 | v2 | v3 | v4 | sq_busy;

endmodule

[rtl/core/ipcc_ctrl.sv]
// ----------------------------------------------------------------------------
// ipcc_ctrl
// Sequencer: point loading, reference pair, pair walk, drain and result.
// ----------------------------------------------------------------------------
module ipcc_ctrl
  import ipcc_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              point_valid,
  input  logic                              final_point,
  output logic                              point_stall,
  output logic                              result_valid,
  input  logic                              result_stall,
  input  logic [FI_W-1:0]                   first_inserted,
  output cmd_t                              cmd,
  input  status_t                           status,
  output logic [$clog2(MAX_POINTS)-1:0]     wr_addr,
  output logic [$clog2(MAX_POINTS)-1:0]     rd_addr,
  output logic [$clog2(MAX_POINTS + 1)-1:0] pair_idx,
  output logic [$clog2(MAX_POINTS + 1)-1:0] init_n
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] TWO_C = CNT_W'(2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REF_LD,
    S_REF_PR,
    S_REF_WAIT,
    S_SETI,
    S_PAIRS,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state;
  logic [CNT_W-1:0] count, n_pts, idx_i, idx_j, count_next;
  logic [CNT_W+FI_W-1:0] fi_ext, n_ext;
  logic accept, has_room, out_free;

  assign accept     = point_valid && (state == S_IDLE);
  assign has_room   = count < MAX_C;
  assign count_next = has_room ? count + CNT_W'(1) : count;
  assign out_free   = !result_valid || !result_stall;
  assign fi_ext     = (CNT_W + FI_W)'(first_inserted);
  assign n_ext      = (CNT_W + FI_W)'(n_pts);

  assign point_stall = (state != S_IDLE);
  assign wr_addr     = count[IDX_W-1:0];
  assign pair_idx    = idx_i;
  assign init_n      = count_next;

  always_comb begin
    cmd     = '0;
    rd_addr = idx_j[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.wr_en = has_room;
          if (final_point) begin
            cmd.init    = 1'b1;
            cmd.too_few = count_next < TWO_C;
          end
        end
      end
      S_REF_LD: begin
        cmd.rd_en   = 1'b1;
        cmd.load_pi = 1'b1;
        rd_addr     = IDX_W'(1);
      end
      S_REF_PR: begin
        cmd.rd_en      = 1'b1;
        cmd.pair_valid = 1'b1;
        cmd.pair_ref   = 1'b1;
        rd_addr        = '0;
      end
      S_SETI: begin
        rd_addr = idx_i[IDX_W-1:0];
        if (idx_i < n_pts && idx_i != '0) begin
          cmd.rd_en   = 1'b1;
          cmd.load_pi = 1'b1;
        end
      end
      S_PAIRS: begin
        cmd.rd_en      = 1'b1;
        cmd.pair_valid = 1'b1;
      end
      S_FINISH: begin
        cmd.load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (final_point) begin
              count <= '0;
              n_pts <= count_next;
              state <= (count_next < TWO_C) ? S_FINISH : S_REF_LD;
            end else begin
              count <= count_next;
            end
          end
        end
        S_REF_LD: state <= S_REF_PR;
        S_REF_PR: state <= S_REF_WAIT;
        S_REF_WAIT: begin
          if (status.ref_done) begin
            if (fi_ext >= n_ext) begin
              state <= S_DRAIN;
            end else begin
              idx_i <= fi_ext[CNT_W-1:0];
              state <= S_SETI;
            end
          end
        end
        S_SETI: begin
          if (idx_i >= n_pts) begin
            state <= S_DRAIN;
          end else if (idx_i == '0) begin
            idx_i <= idx_i + CNT_W'(1);   // index 0 has no earlier point
          end else begin
            idx_j <= '0;
            state <= S_PAIRS;
          end
        end
        S_PAIRS: begin
          if (idx_j + CNT_W'(1) == idx_i) begin
            idx_i <= idx_i + CNT_W'(1);
            state <= S_SETI;
          end else begin
            idx_j <= idx_j + CNT_W'(1);
          end
        end
        S_DRAIN: begin
          if (!status.busy) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/ipcc_checker.sv]
// ----------------------------------------------------------------------------
// ipcc_checker
// Port-level checks for the clash check block, bound to the top level.
// ----------------------------------------------------------------------------
module ipcc_checker
  import ipcc_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    point_valid,
  input logic    point_stall,
  input point_t  point,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // block comes out of reset ready for points
  a_reset_ready: assert property (@(posedge clk)
    rst |=> !point_stall)
    else $error("point channel stalled after reset");

  // a final point always starts a check, so loading stops
  a_final_busy: assert property (@(posedge clk) disable iff (rst)
    point_valid && !point_stall && point.final_point |=> point_stall)
    else $error("point taken while a check should be running");

  // a new result only comes out of a busy period
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(point_stall))
    else $error("result word without a check");

  // too-few word carries zero distance and a count below two
  a_too_few: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.too_few |->
      result.min_distance == '0 && result.problem_index < 9'd2)
    else $error("malformed too-few result");

endmodule

bind inserted_point_clash_check_top ipcc_checker u_ipcc_checker (.*);
